FILE: rtl/ffba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int HEADER_BYTES_DEF = 24;
  localparam int MAX_BLOCKS_DEF   = 64;

  // Configuration register indexes.
  localparam logic REG_HEAP_BASE   = 1'b0;
  localparam logic REG_HEAP_LENGTH = 1'b1;

  // Request modes.
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [1:0] ST_TBL_FULL  = 2'd2;
  localparam logic [1:0] ST_UNKNOWN   = 2'd3;

  typedef struct packed {
    logic        mode;
    logic [31:0] request_bytes;
    logic [47:0] free_address;
  } req_t;

  typedef struct packed {
    logic [47:0] data_address;
    logic [1:0]  status;
  } rsp_t;

  // One block table entry as held by a cell.
  typedef struct packed {
    logic [31:0] offset;
    logic [31:0] bytes;
    logic        is_free;
    logic        dead;
  } entry_t;

  // What every cell of the chain does in a cycle.
  typedef enum logic [1:0] {
    CM_HOLD,
    CM_SHL,
    CM_SHR,
    CM_COMPACT
  } cell_mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_ALLOC,
    S_FIND,
    S_MERGE,
    S_COMPACT,
    S_DONE
  } state_t;

endpackage

FILE: rtl/ffba_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_cell
// One entry of the block table; shifts toward either neighbor or closes a gap.
// ----------------------------------------------------------------------------
module ffba_cell
  import ffba_pkg::*;
(
  input  logic       clk,
  input  cell_mode_t mode,
  input  entry_t     left_in,
  input  entry_t     right_in,
  input  logic       hole_in,
  output logic       hole_out,
  output entry_t     q
);

  entry_t entry_r;

  // A gap exists at or before this cell.
  assign hole_out = hole_in | entry_r.dead;
  assign q        = entry_r;

  // Entry register.
  always_ff @(posedge clk) begin
    case (mode)
      CM_SHL:     entry_r <= right_in;
      CM_SHR:     entry_r <= left_in;
      CM_COMPACT: begin
        if (hole_out) begin
          entry_r <= right_in;
        end
      end
      default:    entry_r <= entry_r;
    endcase
  end

endmodule

FILE: rtl/first_fit_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit heap allocator over an address-ordered table held in a cell chain.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its one result shows
// on out_item for a single cycle with out_valid high, and the receiver cannot
// stall it. The table rotates through the chain one entry per cycle; an
// allocate checks the fit and rotates it once, a free of a null address just
// reports, a free of an unknown address rotates it once, and a successful free
// rotates it forward, then backward to merge free blocks, then closes each gap.
// ----------------------------------------------------------------------------
module first_fit_block_allocator
  import ffba_pkg::*;
#(
  parameter int HEADER_BYTES = HEADER_BYTES_DEF,
  parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  req_t        in_item,
  output logic        out_valid,
  output rsp_t        out_item,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [47:0] cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam logic [CNT_W-1:0] MAXC  = CNT_W'(MAX_BLOCKS);
  localparam logic [CNT_W-1:0] LASTC = CNT_W'(MAX_BLOCKS - 1);
  localparam logic [33:0] HDR34 = 34'(HEADER_BYTES);
  localparam logic [47:0] HDR48 = 48'(HEADER_BYTES);
  localparam logic [31:0] HDR32 = 32'(HEADER_BYTES);

  // Cell chain.
  cell_mode_t cmode;
  entry_t     feed;
  entry_t     cell_q [MAX_BLOCKS];
  logic       hole_c [MAX_BLOCKS+1];

  assign hole_c[0] = 1'b0;

  for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
    entry_t lin, rin;
    assign lin = (i == 0) ? feed : cell_q[(i == 0) ? 0 : i-1];
    assign rin = (i == MAX_BLOCKS-1) ? feed : cell_q[(i == MAX_BLOCKS-1) ? i : i+1];
    ffba_cell u_cell (
      .clk      (clk),
      .mode     (cmode),
      .left_in  (lin),
      .right_in (rin),
      .hole_in  (hole_c[i]),
      .hole_out (hole_c[i+1]),
      .q        (cell_q[i])
    );
  end

  // Control and state registers.
  state_t         state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] match_r, match_nxt;
  logic [CNT_W-1:0] drops_r, drops_nxt;
  logic [32:0]    bump_r, bump_nxt;
  logic [47:0]    base_r;
  logic [31:0]    len_r;
  logic           mode_r, mode_nxt;
  logic [32:0]    size_r, size_nxt;
  logic [47:0]    addr_r, addr_nxt;
  logic           found_r, found_nxt;
  logic [31:0]    foff_r, foff_nxt;
  logic           fail_r, fail_nxt;
  logic [1:0]     stat_r, stat_nxt;
  entry_t         hold_r, hold_nxt;
  logic           hold_v_r, hold_v_nxt;
  logic [31:0]    acc_r, acc_nxt;
  logic           out_valid_r, out_valid_nxt;
  rsp_t           out_r, out_nxt;

  // Helper values.
  logic [32:0]      round_sz;
  logic [33:0]      carve_end;
  logic [47:0]      head_addr;
  logic [CNT_W-1:0] mtidx;
  logic             head_v, head_free;
  entry_t           head_m;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  assign round_sz  = ({1'b0, in_item.request_bytes} + 33'd7) & ~33'd7;
  assign carve_end = {1'b0, bump_r} + HDR34 + {1'b0, size_r};
  assign head_addr = base_r + {16'd0, cell_q[0].offset} + HDR48;
  assign mtidx     = LASTC - cnt_r;

  // Head of the chain while it rotates toward the high end.
  always_comb begin
    head_v    = (cnt_r < MAXC) && (mtidx < count_r);
    head_free = head_v && (cell_q[MAX_BLOCKS-1].is_free || (mtidx == match_r));
    head_m         = cell_q[MAX_BLOCKS-1];
    head_m.is_free = head_v ? head_free : cell_q[MAX_BLOCKS-1].is_free;
    head_m.dead    = 1'b0;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      len_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEAP_BASE:   base_r <= cfg_wdata;
        REG_HEAP_LENGTH: len_r  <= cfg_wdata[31:0];
        default:         base_r <= base_r;
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      count_r     <= '0;
      bump_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      count_r     <= count_nxt;
      bump_r      <= bump_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    match_r  <= match_nxt;
    drops_r  <= drops_nxt;
    mode_r   <= mode_nxt;
    size_r   <= size_nxt;
    addr_r   <= addr_nxt;
    found_r  <= found_nxt;
    foff_r   <= foff_nxt;
    fail_r   <= fail_nxt;
    stat_r   <= stat_nxt;
    hold_r   <= hold_nxt;
    hold_v_r <= hold_v_nxt;
    acc_r    <= acc_nxt;
    out_r    <= out_nxt;
  end

  // Sequencer: next state, chain control and result.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    count_nxt     = count_r;
    match_nxt     = match_r;
    drops_nxt     = drops_r;
    bump_nxt      = bump_r;
    mode_nxt      = mode_r;
    size_nxt      = size_r;
    addr_nxt      = addr_r;
    found_nxt     = found_r;
    foff_nxt      = foff_r;
    fail_nxt      = fail_r;
    stat_nxt      = stat_r;
    hold_nxt      = hold_r;
    hold_v_nxt    = hold_v_r;
    acc_nxt       = acc_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    cmode         = CM_HOLD;
    feed          = cell_q[0];

    case (state_r)
      S_IDLE: begin
        if (start) begin
          mode_nxt  = in_item.mode;
          size_nxt  = (round_sz == 33'd0) ? 33'd8 : round_sz;
          addr_nxt  = in_item.free_address;
          found_nxt = 1'b0;
          drops_nxt = '0;
          stat_nxt  = ST_OK;
          cnt_nxt   = '0;
          if (in_item.mode == MODE_ALLOC) begin
            state_nxt = S_CALC;
          end else if (in_item.free_address == 48'd0) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_FIND;
          end
        end
      end

      S_CALC: begin
        fail_nxt  = (carve_end > {2'b00, len_r});
        state_nxt = S_ALLOC;
      end

      // Forward rotation: first fit, or carve at the end of the table.
      S_ALLOC: begin
        cmode = CM_SHL;
        feed  = cell_q[0];
        if ((cnt_r < count_r) && !found_r && cell_q[0].is_free &&
            ({1'b0, cell_q[0].bytes} >= size_r)) begin
          feed.is_free = 1'b0;
          found_nxt    = 1'b1;
          foff_nxt     = cell_q[0].offset;
        end else if ((cnt_r == count_r) && !found_r && !fail_r) begin
          feed.offset  = bump_r[31:0];
          feed.bytes   = size_r[31:0];
          feed.is_free = 1'b0;
          feed.dead    = 1'b0;
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LASTC) begin
          state_nxt = S_DONE;
        end
      end

      // Forward rotation: look up the block by its data address.
      S_FIND: begin
        cmode = CM_SHL;
        feed  = cell_q[0];
        if ((cnt_r < count_r) && !found_r && (head_addr == addr_r)) begin
          found_nxt = 1'b1;
          match_nxt = cnt_r;
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LASTC) begin
          cnt_nxt = '0;
          acc_nxt = '0;
          if (found_nxt) begin
            state_nxt = S_MERGE;
          end else begin
            stat_nxt  = ST_UNKNOWN;
            state_nxt = S_DONE;
          end
        end
      end

      // Backward rotation through a one-entry holder: a free block followed
      // by a free block is folded into it and leaves a gap.
      S_MERGE: begin
        cmode = CM_SHR;
        feed  = hold_r;
        if (cnt_r != '0) begin
          if (hold_v_r && hold_r.is_free && head_free) begin
            feed.dead = 1'b1;
            acc_nxt   = acc_r + hold_r.bytes + HDR32;
            drops_nxt = drops_r + 1'b1;
          end else begin
            feed.bytes = hold_r.bytes + acc_r;
            acc_nxt    = '0;
          end
        end
        hold_nxt   = head_m;
        hold_v_nxt = head_v;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == MAXC) begin
          cnt_nxt   = '0;
          state_nxt = (drops_nxt != '0) ? S_COMPACT : S_DONE;
        end
      end

      // Close the first gap each cycle.
      S_COMPACT: begin
        cmode      = CM_COMPACT;
        feed       = cell_q[MAX_BLOCKS-1];
        feed.dead  = 1'b1;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_nxt == drops_r) begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        out_valid_nxt        = 1'b1;
        out_nxt.data_address = '0;
        out_nxt.status       = stat_r;
        if (mode_r == MODE_ALLOC) begin
          if (found_r) begin
            out_nxt.data_address = base_r + {16'd0, foff_r} + HDR48;
            out_nxt.status       = ST_OK;
          end else if (fail_r) begin
            out_nxt.status = ST_NO_SPACE;
          end else if (count_r == MAXC) begin
            out_nxt.status = ST_TBL_FULL;
          end else begin
            out_nxt.data_address = base_r + {15'd0, bump_r} + HDR48;
            out_nxt.status       = ST_OK;
            count_nxt            = count_r + 1'b1;
            bump_nxt             = carve_end[32:0];
          end
        end else begin
          count_nxt = count_r - drops_r;
        end
        state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
